/* design/smhp_pkg.sv */
// Shared types and codes for the SNMP message header parser.
// Holds parse phase codes, byte role codes and the parser state record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smhp_pkg;

	localparam logic [7:0] SEQ_TAG_BYTE = 8'h30;

	localparam logic [3:0] PH_SEQ_TAG      = 4'd0;
	localparam logic [3:0] PH_SEQ_LEN      = 4'd1;
	localparam logic [3:0] PH_SEQ_LEN_EXT  = 4'd2;
	localparam logic [3:0] PH_VER_TAG      = 4'd3;
	localparam logic [3:0] PH_VER_LEN      = 4'd4;
	localparam logic [3:0] PH_VER_LEN_EXT  = 4'd5;
	localparam logic [3:0] PH_VER_VAL      = 4'd6;
	localparam logic [3:0] PH_COMM_TAG     = 4'd7;
	localparam logic [3:0] PH_COMM_LEN     = 4'd8;
	localparam logic [3:0] PH_COMM_LEN_EXT = 4'd9;
	localparam logic [3:0] PH_COMM_VAL     = 4'd10;
	localparam logic [3:0] PH_PDU          = 4'd11;
	localparam logic [3:0] PH_REJECTED     = 4'd12;

	localparam logic [3:0] ROLE_SEQ_TAG   = 4'd0;
	localparam logic [3:0] ROLE_SEQ_LEN   = 4'd1;
	localparam logic [3:0] ROLE_VER_TAG   = 4'd2;
	localparam logic [3:0] ROLE_VER_LEN   = 4'd3;
	localparam logic [3:0] ROLE_VER_VAL   = 4'd4;
	localparam logic [3:0] ROLE_COMM_TAG  = 4'd5;
	localparam logic [3:0] ROLE_COMM_LEN  = 4'd6;
	localparam logic [3:0] ROLE_COMM_VAL  = 4'd7;
	localparam logic [3:0] ROLE_PDU       = 4'd8;
	localparam logic [3:0] ROLE_REJECTED  = 4'd9;

	typedef struct packed {
		logic [3:0]  phase;
		logic [6:0]  len_left;
		logic [15:0] len_acc;
		logic [15:0] val_left;
		logic [15:0] seq_len;
		logic [31:0] version;
		logic [15:0] comm_len;
		logic        reject;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:    PH_SEQ_TAG,
		len_left: 7'd0,
		len_acc:  16'd0,
		val_left: 16'd0,
		seq_len:  16'd0,
		version:  32'd0,
		comm_len: 16'd0,
		reject:   1'b0
	};

endpackage

`default_nettype wire

/* design/smhp_next.sv */
// Per-byte next-state and role logic of the SNMP message header parser.
// Purely combinational; depends on smhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smhp_next (
	input  wire smhp_pkg::parse_state_t cur,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   start_of_datagram,
	output smhp_pkg::parse_state_t      nxt,
	output logic [3:0]                  byte_role
);

	localparam logic [1:0] FLD_SEQ  = 2'd0;
	localparam logic [1:0] FLD_VER  = 2'd1;
	localparam logic [1:0] FLD_COMM = 2'd2;

	function automatic smhp_pkg::parse_state_t len_done(
		smhp_pkg::parse_state_t s, logic [1:0] fld, logic [15:0] len);
		smhp_pkg::parse_state_t r;
		r = s;
		case (fld)
			FLD_SEQ: begin
				r.seq_len = len;
				r.phase   = smhp_pkg::PH_VER_TAG;
			end
			FLD_VER: begin
				r.version  = 32'd0;
				r.val_left = len;
				r.phase    = (len != 16'd0) ? smhp_pkg::PH_VER_VAL : smhp_pkg::PH_COMM_TAG;
			end
			default: begin
				r.comm_len = len;
				r.val_left = len;
				r.phase    = (len != 16'd0) ? smhp_pkg::PH_COMM_VAL : smhp_pkg::PH_PDU;
			end
		endcase
		return r;
	endfunction

	function automatic smhp_pkg::parse_state_t len_first(
		smhp_pkg::parse_state_t s, logic [1:0] fld, logic [7:0] b, logic [3:0] ext_ph);
		smhp_pkg::parse_state_t r;
		r = s;
		if (!b[7]) begin
			r = len_done(s, fld, {8'd0, b});
		end else if (b[6:0] == 7'd0) begin
			r = len_done(s, fld, 16'd0);
		end else begin
			r.len_left = b[6:0];
			r.len_acc  = 16'd0;
			if (fld == FLD_SEQ)
				r.seq_len = 16'd0;
			if (fld == FLD_COMM)
				r.comm_len = 16'd0;
			r.phase = ext_ph;
		end
		return r;
	endfunction

	function automatic smhp_pkg::parse_state_t len_ext(
		smhp_pkg::parse_state_t s, logic [1:0] fld, logic [7:0] b);
		smhp_pkg::parse_state_t r;
		r = s;
		r.len_acc = {s.len_acc[7:0], b};
		if (fld == FLD_SEQ)
			r.seq_len = r.len_acc;
		if (fld == FLD_COMM)
			r.comm_len = r.len_acc;
		r.len_left = s.len_left - 7'd1;
		if (r.len_left == 7'd0)
			r = len_done(r, fld, r.len_acc);
		return r;
	endfunction

	smhp_pkg::parse_state_t base;

	always_comb begin
		base      = start_of_datagram ? smhp_pkg::STATE_RESET : cur;
		nxt       = base;
		byte_role = smhp_pkg::ROLE_REJECTED;
		case (base.phase)
			smhp_pkg::PH_SEQ_TAG: begin
				if (data_byte == smhp_pkg::SEQ_TAG_BYTE) begin
					byte_role = smhp_pkg::ROLE_SEQ_TAG;
					nxt.phase = smhp_pkg::PH_SEQ_LEN;
				end else begin
					nxt.reject = 1'b1;
					nxt.phase  = smhp_pkg::PH_REJECTED;
				end
			end
			smhp_pkg::PH_SEQ_LEN: begin
				byte_role = smhp_pkg::ROLE_SEQ_LEN;
				nxt = len_first(base, FLD_SEQ, data_byte, smhp_pkg::PH_SEQ_LEN_EXT);
			end
			smhp_pkg::PH_SEQ_LEN_EXT: begin
				byte_role = smhp_pkg::ROLE_SEQ_LEN;
				nxt = len_ext(base, FLD_SEQ, data_byte);
			end
			smhp_pkg::PH_VER_TAG: begin
				byte_role = smhp_pkg::ROLE_VER_TAG;
				nxt.phase = smhp_pkg::PH_VER_LEN;
			end
			smhp_pkg::PH_VER_LEN: begin
				byte_role = smhp_pkg::ROLE_VER_LEN;
				nxt = len_first(base, FLD_VER, data_byte, smhp_pkg::PH_VER_LEN_EXT);
			end
			smhp_pkg::PH_VER_LEN_EXT: begin
				byte_role = smhp_pkg::ROLE_VER_LEN;
				nxt = len_ext(base, FLD_VER, data_byte);
			end
			smhp_pkg::PH_VER_VAL: begin
				byte_role    = smhp_pkg::ROLE_VER_VAL;
				nxt.version  = {base.version[23:0], data_byte};
				nxt.val_left = base.val_left - 16'd1;
				if (nxt.val_left == 16'd0)
					nxt.phase = smhp_pkg::PH_COMM_TAG;
			end
			smhp_pkg::PH_COMM_TAG: begin
				byte_role = smhp_pkg::ROLE_COMM_TAG;
				nxt.phase = smhp_pkg::PH_COMM_LEN;
			end
			smhp_pkg::PH_COMM_LEN: begin
				byte_role = smhp_pkg::ROLE_COMM_LEN;
				nxt = len_first(base, FLD_COMM, data_byte, smhp_pkg::PH_COMM_LEN_EXT);
			end
			smhp_pkg::PH_COMM_LEN_EXT: begin
				byte_role = smhp_pkg::ROLE_COMM_LEN;
				nxt = len_ext(base, FLD_COMM, data_byte);
			end
			smhp_pkg::PH_COMM_VAL: begin
				byte_role    = smhp_pkg::ROLE_COMM_VAL;
				nxt.val_left = base.val_left - 16'd1;
				if (nxt.val_left == 16'd0)
					nxt.phase = smhp_pkg::PH_PDU;
			end
			smhp_pkg::PH_PDU: begin
				byte_role = smhp_pkg::ROLE_PDU;
			end
			default: begin
				nxt.reject = 1'b1;
				nxt.phase  = smhp_pkg::PH_REJECTED;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/snmp_message_header_parser_core.sv */
// Top level of the SNMP message header parser: input register, parser state
// and result register. Depends on smhp_pkg and smhp_next.
`timescale 1ns / 1ps
`default_nettype none

// Takes a received datagram one byte per transaction on the slave side and
// returns one labelled transaction per byte on the master side, carrying the
// byte, its role and the header values decoded so far. Mark the first byte of
// each datagram with s_tuser; a datagram whose first byte is not 0x30 is
// rejected until the next start mark. Throughput is one byte per cycle with no
// gaps while m_tready is not held low; each byte passes through the input
// register and the result register around the parser state update.
module snmp_message_header_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic [0:0]  s_tuser,   // [0] start_of_datagram
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // [7:0] byte_out, [23:8] message_length,
	                                    // [55:24] version_value,
	                                    // [71:56] community_length,
	                                    // [72] header_done, [73] rejected, rest zero
	output logic [3:0]       m_tuser    // [3:0] byte_role
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   start_s1;
	logic                   advance;
	logic                   fire;
	smhp_pkg::parse_state_t state_q;
	smhp_pkg::parse_state_t state_nxt;
	logic [3:0]             role_nxt;

	logic                   out_valid_q;
	logic [3:0]             out_role_q;
	logic [7:0]             out_byte_q;
	logic [15:0]            out_msg_len_q;
	logic [31:0]            out_version_q;
	logic [15:0]            out_comm_len_q;
	logic                   out_done_q;
	logic                   out_reject_q;

	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
	end

	smhp_next u_next (
		.cur               (state_q),
		.data_byte         (byte_s1),
		.start_of_datagram (start_s1),
		.nxt               (state_nxt),
		.byte_role         (role_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smhp_pkg::STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (fire)
				state_q <= state_nxt;
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_role_q     <= role_nxt;
			out_byte_q     <= byte_s1;
			out_msg_len_q  <= state_nxt.seq_len;
			out_version_q  <= state_nxt.version;
			out_comm_len_q <= state_nxt.comm_len;
			out_done_q     <= (state_nxt.phase == smhp_pkg::PH_PDU);
			out_reject_q   <= state_nxt.reject;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_role_q;
	assign m_tdata  = {6'd0, out_reject_q, out_done_q, out_comm_len_q, out_version_q,
		out_msg_len_q, out_byte_q};

`ifndef SYNTHESIS
	a_reject_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.reject |-> state_q.phase == smhp_pkg::PH_REJECTED)
		else $error("reject flag set outside the rejected phase");

	a_reject_role: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_reject_q |-> out_role_q == smhp_pkg::ROLE_REJECTED)
		else $error("rejected byte carries a parsing role");

	a_done_role: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_done_q |-> !out_reject_q && (out_role_q == smhp_pkg::ROLE_PDU
		|| out_role_q == smhp_pkg::ROLE_COMM_VAL || out_role_q == smhp_pkg::ROLE_COMM_LEN))
		else $error("header done on a header byte");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(state_q))
		else $error("input stage or state moved during a stall");

	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed byte produced no result");
`endif

endmodule

`default_nettype wire

/* test/tb_snmp_message_header_parser_core.sv */
`timescale 1ns / 1ps
// Testbench for snmp_message_header_parser_core: streams directed and random
// datagrams through the parser and checks every labelled byte against an
// independent header decoder. Depends on smhp_pkg and the core RTL.
module tb_snmp_message_header_parser_core;

	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned TOTAL_BYTES = 824;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam logic [7:0] LONG_FORM_BIT = 8'h80;
	localparam int FLD_SEQ = 0;
	localparam int FLD_VER = 1;
	localparam int FLD_COMM = 2;

	typedef struct packed {
		logic [7:0] data;
		logic       sof;
	} datagram_byte_t;

	typedef struct packed {
		logic [3:0]  role;
		logic [7:0]  data;
		logic [15:0] msg_len;
		logic [31:0] version;
		logic [15:0] comm_len;
		logic        done;
		logic        rej;
	} header_view_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic [0:0]  s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [3:0]  m_tuser;

	datagram_byte_t         pending_bytes[$];
	header_view_t           expected_views[$];
	smhp_pkg::parse_state_t parser = smhp_pkg::STATE_RESET;
	datagram_byte_t         next_byte;
	header_view_t           want;

	int gap_left = 0;
	int stall_left = 0;
	bit send_calm = 1'b0;
	bit take_calm = 1'b0;
	int unsigned idle_cycles = 0;
	int unsigned errors = 0;
	int unsigned results_checked = 0;
	int unsigned datagrams_seen = 0;
	int unsigned rejected_bytes = 0;
	int unsigned pdu_bytes = 0;

	logic [8:0] opening_bytes [24] = '{
		{1'b0, smhp_pkg::SEQ_TAG_BYTE}, 9'h080, 9'h002, 9'h000, 9'h004, 9'h000, 9'h0FF,
		9'h1A5, {1'b0, smhp_pkg::SEQ_TAG_BYTE},
		{1'b1, smhp_pkg::SEQ_TAG_BYTE}, 9'h082, 9'h0FF, 9'h0FF, 9'h002, 9'h081, 9'h002,
		9'h0FF, 9'h000, 9'h004, 9'h001, 9'h000, 9'h07F,
		{1'b1, smhp_pkg::SEQ_TAG_BYTE}, 9'h07F
	};

	snmp_message_header_parser_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	function automatic void close_length(int field, logic [15:0] len);
		case (field)
		FLD_SEQ: begin
			parser.seq_len = len;
			parser.phase = smhp_pkg::PH_VER_TAG;
		end
		FLD_VER: begin
			parser.version = '0;
			parser.val_left = len;
			parser.phase = (len != 16'd0) ? smhp_pkg::PH_VER_VAL : smhp_pkg::PH_COMM_TAG;
		end
		default: begin
			parser.comm_len = len;
			parser.val_left = len;
			parser.phase = (len != 16'd0) ? smhp_pkg::PH_COMM_VAL : smhp_pkg::PH_PDU;
		end
		endcase
	endfunction

	function automatic void open_length(int field, logic [7:0] b, logic [3:0] ext_phase);
		if (b < LONG_FORM_BIT) begin
			close_length(field, {8'h00, b});
		end else if (b == LONG_FORM_BIT) begin
			close_length(field, 16'h0000);
		end else begin
			parser.len_left = b[6:0];
			parser.len_acc = '0;
			if (field == FLD_SEQ) parser.seq_len = '0;
			if (field == FLD_COMM) parser.comm_len = '0;
			parser.phase = ext_phase;
		end
	endfunction

	function automatic void extend_length(int field, logic [7:0] b);
		parser.len_acc = {parser.len_acc[7:0], b};
		if (field == FLD_SEQ) parser.seq_len = parser.len_acc;
		if (field == FLD_COMM) parser.comm_len = parser.len_acc;
		parser.len_left = parser.len_left - 7'd1;
		if (parser.len_left == 7'd0) close_length(field, parser.len_acc);
	endfunction

	function automatic header_view_t advance_parser(logic [7:0] b, logic sof);
		header_view_t v;
		if (sof) parser = smhp_pkg::STATE_RESET;
		case (parser.phase)
		smhp_pkg::PH_SEQ_TAG: begin
			if (b == smhp_pkg::SEQ_TAG_BYTE) begin
				v.role = smhp_pkg::ROLE_SEQ_TAG;
				parser.phase = smhp_pkg::PH_SEQ_LEN;
			end else begin
				v.role = smhp_pkg::ROLE_REJECTED;
				parser.reject = 1'b1;
				parser.phase = smhp_pkg::PH_REJECTED;
			end
		end
		smhp_pkg::PH_SEQ_LEN: begin
			v.role = smhp_pkg::ROLE_SEQ_LEN;
			open_length(FLD_SEQ, b, smhp_pkg::PH_SEQ_LEN_EXT);
		end
		smhp_pkg::PH_SEQ_LEN_EXT: begin
			v.role = smhp_pkg::ROLE_SEQ_LEN;
			extend_length(FLD_SEQ, b);
		end
		smhp_pkg::PH_VER_TAG: begin
			v.role = smhp_pkg::ROLE_VER_TAG;
			parser.phase = smhp_pkg::PH_VER_LEN;
		end
		smhp_pkg::PH_VER_LEN: begin
			v.role = smhp_pkg::ROLE_VER_LEN;
			open_length(FLD_VER, b, smhp_pkg::PH_VER_LEN_EXT);
		end
		smhp_pkg::PH_VER_LEN_EXT: begin
			v.role = smhp_pkg::ROLE_VER_LEN;
			extend_length(FLD_VER, b);
		end
		smhp_pkg::PH_VER_VAL: begin
			v.role = smhp_pkg::ROLE_VER_VAL;
			parser.version = {parser.version[23:0], b};
			parser.val_left = parser.val_left - 16'd1;
			if (parser.val_left == 16'd0) parser.phase = smhp_pkg::PH_COMM_TAG;
		end
		smhp_pkg::PH_COMM_TAG: begin
			v.role = smhp_pkg::ROLE_COMM_TAG;
			parser.phase = smhp_pkg::PH_COMM_LEN;
		end
		smhp_pkg::PH_COMM_LEN: begin
			v.role = smhp_pkg::ROLE_COMM_LEN;
			open_length(FLD_COMM, b, smhp_pkg::PH_COMM_LEN_EXT);
		end
		smhp_pkg::PH_COMM_LEN_EXT: begin
			v.role = smhp_pkg::ROLE_COMM_LEN;
			extend_length(FLD_COMM, b);
		end
		smhp_pkg::PH_COMM_VAL: begin
			v.role = smhp_pkg::ROLE_COMM_VAL;
			parser.val_left = parser.val_left - 16'd1;
			if (parser.val_left == 16'd0) parser.phase = smhp_pkg::PH_PDU;
		end
		smhp_pkg::PH_PDU: begin
			v.role = smhp_pkg::ROLE_PDU;
		end
		default: begin
			v.role = smhp_pkg::ROLE_REJECTED;
			parser.reject = 1'b1;
			parser.phase = smhp_pkg::PH_REJECTED;
		end
		endcase
		v.data = b;
		v.msg_len = parser.seq_len;
		v.version = parser.version;
		v.comm_len = parser.comm_len;
		v.done = (parser.phase == smhp_pkg::PH_PDU);
		v.rej = parser.reject;
		return v;
	endfunction

	function automatic void put_byte(logic [7:0] b, logic sof);
		pending_bytes.push_back('{data: b, sof: sof});
	endfunction

	function automatic void put_length(int unsigned value, int unsigned nbytes);
		logic [7:0] part;
		if (nbytes == 0 && value == 0 && $urandom_range(0, 3) == 0) begin
			put_byte(LONG_FORM_BIT, 1'b0);
		end else if (nbytes == 0 && value < 128) begin
			part = 8'(value);
			put_byte(part, 1'b0);
		end else begin
			if (nbytes == 0) nbytes = 2;
			part = 8'(nbytes);
			put_byte(LONG_FORM_BIT | part, 1'b0);
			for (int i = nbytes - 1; i >= 0; i--) begin
				part = (i < 4) ? 8'(value >> (8 * i)) : 8'h00;
				put_byte(part, 1'b0);
			end
		end
	endfunction

	function automatic int unsigned pick_len_bytes();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 80) return 1;
		if (r < 93) return 2;
		if (r < 98) return $urandom_range(3, 4);
		return $urandom_range(5, 127);
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void report(string field, logic [31:0] exp_val, logic [31:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", field, exp_val, got_val);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_views.push_back(advance_parser(s_tdata, s_tuser[0]));
				if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					next_byte = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_byte.data;
					s_tuser <= next_byte.sof;
					gap_left = send_calm ? 0 : pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_views.size() == 0) begin
					$error("unexpected transaction: tuser %0h tdata %0h", m_tuser, m_tdata);
					errors++;
				end else begin
					want = expected_views.pop_front();
					report("byte_role", 32'(want.role), 32'(m_tuser));
					report("byte_out", 32'(want.data), 32'(m_tdata[7:0]));
					report("message_length", 32'(want.msg_len), 32'(m_tdata[23:8]));
					report("version_value", want.version, m_tdata[55:24]);
					report("community_length", 32'(want.comm_len), 32'(m_tdata[71:56]));
					report("header_done", 32'(want.done), 32'(m_tdata[72]));
					report("rejected", 32'(want.rej), 32'(m_tdata[73]));
					report("tdata padding", 32'd0, 32'(m_tdata[79:74]));
					results_checked++;
					if (want.role == smhp_pkg::ROLE_SEQ_TAG) datagrams_seen++;
					if (want.role == smhp_pkg::ROLE_REJECTED) rejected_bytes++;
					if (want.role == smhp_pkg::ROLE_PDU) pdu_bytes++;
				end
				if ($urandom_range(0, 63) == 0) take_calm = !take_calm;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!take_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int unsigned frame_start;
		int unsigned ver_len;
		int unsigned comm_len;
		int unsigned cut;
		int unsigned r;
		logic [7:0] first;

		foreach (opening_bytes[i]) put_byte(opening_bytes[i][7:0], opening_bytes[i][8]);

		while (pending_bytes.size() < TOTAL_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				frame_start = pending_bytes.size();
				put_byte(smhp_pkg::SEQ_TAG_BYTE, 1'b1);
				put_length($urandom_range(0, 65535), pick_len_bytes());
				put_byte(8'($urandom), 1'b0);
				ver_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
				put_length(ver_len, pick_len_bytes());
				repeat (ver_len) put_byte(8'($urandom), 1'b0);
				put_byte(8'($urandom), 1'b0);
				comm_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 12);
				put_length(comm_len, pick_len_bytes());
				repeat ((comm_len < 16) ? comm_len : 16) put_byte(8'($urandom), 1'b0);
				repeat ($urandom_range(0, 8)) put_byte(8'($urandom), 1'b0);
				// cut the datagram short now and then
				if ($urandom_range(0, 6) == 0) begin
					cut = $urandom_range(frame_start + 1, pending_bytes.size());
					while (pending_bytes.size() > cut) void'(pending_bytes.pop_back());
				end
			end else if (r < 87) begin
				first = 8'($urandom);
				if (first == smhp_pkg::SEQ_TAG_BYTE) first = ~first;
				put_byte(first, 1'b1);
				repeat ($urandom_range(0, 5)) put_byte(8'($urandom), 1'b0);
			end else begin
				repeat ($urandom_range(1, 6))
					put_byte(8'($urandom), $urandom_range(0, 3) == 0);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (pending_bytes.size() != 0 || s_tvalid || expected_views.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d labelled bytes over %0d datagrams opened by a sequence tag,",
			results_checked, datagrams_seen);
		$display("with %0d rejected bytes and %0d PDU bytes; %0d mismatches.",
			rejected_bytes, pdu_bytes, errors);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
design/smhp_pkg.sv
design/smhp_next.sv
design/snmp_message_header_parser_core.sv
test/tb_snmp_message_header_parser_core.sv
